// ===== rtl/dtq_pkg.sv =====
`timescale 1ns / 1ps

package dtq_pkg;

  // Number of cells in the chain and width of a stored deadline
  localparam int DEPTH     = 16;
  localparam int TIME_BITS = 32;

  // Entry ids are a fixed 4-bit field
  localparam int ID_BITS = 4;
  localparam int NUM_IDS = 1 << ID_BITS;

  // External field widths
  localparam int EXT_TIME_BITS = 32;
  localparam int TAG_BITS      = 32;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [ID_BITS-1:0]   id_t;
  typedef logic [TAG_BITS-1:0]  tag_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_TICK   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_DELETED  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FIRED    = 3'd4,
    ST_NONE     = 3'd5
  } status_t;

  // Command broadcast to every cell in a cycle
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_DELETE,
    CMD_POP
  } cell_cmd_t;

  typedef enum logic {
    S_IDLE,
    S_TICK
  } state_t;

  typedef struct packed {
    time_t expire;
    tag_t  tag;
    id_t   id;
  } entry_t;

  // What a cell shows its neighbors
  typedef struct packed {
    entry_t entry;
    logic   valid;
    logic   place;  // new entry goes at or before this cell
    logic   found;  // delete id matched here or in a cell to the left
  } link_t;

endpackage

// ===== rtl/dtq_cell.sv =====
`timescale 1ns / 1ps

module dtq_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  dtq_pkg::cell_cmd_t  cmd,
  input  dtq_pkg::entry_t     new_entry,
  input  dtq_pkg::id_t        del_id,
  input  dtq_pkg::link_t      left_link,
  input  dtq_pkg::link_t      right_link,
  output dtq_pkg::link_t      link
);
  import dtq_pkg::*;

  entry_t entry_r, entry_nxt;
  logic   valid_r, valid_nxt;
  logic   place;
  logic   found;

  // Sorted chain: new entry lands before the first strictly later deadline
  assign place = !valid_r || (entry_r.expire > new_entry.expire);
  assign found = left_link.found || (valid_r && (entry_r.id == del_id));

  assign link.entry = entry_r;
  assign link.valid = valid_r;
  assign link.place = place;
  assign link.found = found;

  // Next contents: hold, shift right on insert, shift left on delete or pop
  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    case (cmd)
      CMD_INSERT: begin
        if (place) begin
          entry_nxt = left_link.place ? left_link.entry : new_entry;
          valid_nxt = valid_r | left_link.valid;
        end
      end
      CMD_DELETE: begin
        if (found) begin
          entry_nxt = right_link.entry;
          valid_nxt = right_link.valid;
        end
      end
      CMD_POP: begin
        entry_nxt = right_link.entry;
        valid_nxt = right_link.valid;
      end
      default: begin
        entry_nxt = entry_r;
        valid_nxt = valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ===== rtl/deadline_timer_queue.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake            Contents
// in_       in   in_tvalid/in_tready  tuser: op; tdata: expire, tag, entry id, now
// out_      out  out_tvalid/out_tready tuser: status; tdata: id, tag, expire; tlast
//
// Insert and delete each shift the whole cell chain at once.
// A tick first captures the time, then returns each fired entry in turn
// (the head cell is popped and the chain shifts left), or else the idle
// result. The next transaction is taken once the tick is done.
// Synchronous active-low reset empties the chain and frees all ids.
// A stalled output holds its result; the chain waits until the slot frees.

module deadline_timer_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [1:0]    in_tuser,   // [1:0] op
  input  logic [103:0]  in_tdata,   // [31:0] expire_time, [63:32] event_tag,
                                    // [67:64] entry_id, [99:68] now_time, rest zero
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [2:0]    out_tuser,  // [2:0] status
  output logic [71:0]   out_tdata,  // [3:0] out_id, [35:4] out_tag,
                                    // [67:36] out_expire, rest zero
  output logic          out_tlast
);
  import dtq_pkg::*;

  // Input fields
  op_t    in_op;
  time_t  in_expire;
  tag_t   in_tag;
  id_t    in_id;
  time_t  in_now;

  assign in_op     = op_t'(in_tuser[1:0]);
  assign in_expire = time_t'(in_tdata[31:0]);
  assign in_tag    = in_tdata[63:32];
  assign in_id     = in_tdata[67:64];
  assign in_now    = time_t'(in_tdata[99:68]);

  // Control and bookkeeping
  state_t               state_r, state_nxt;
  logic [NUM_IDS-1:0]   id_use_r, id_use_nxt;
  time_t                now_r, now_nxt;
  cell_cmd_t            cmd;
  entry_t               new_entry;
  id_t                  free_id;

  // Output register
  logic     out_valid_r;
  status_t  out_status_r, out_status_nxt;
  id_t      out_id_r, out_id_nxt;
  tag_t     out_tag_r, out_tag_nxt;
  time_t    out_expire_r, out_expire_nxt;
  logic     out_last_r, out_last_nxt;
  logic     load;
  logic     slot_free;
  logic     in_fire;

  // Cell chain
  link_t links [DEPTH];
  link_t left_edge;
  link_t right_edge;

  logic full;
  logic found;
  logic head_fired;
  logic next_fired;

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && slot_free;
  assign in_fire   = in_tvalid && in_tready;

  assign new_entry.expire = in_expire;
  assign new_entry.tag    = in_tag;
  assign new_entry.id     = free_id;

  assign left_edge.entry  = '0;
  assign left_edge.valid  = 1'b1;
  assign left_edge.place  = 1'b0;
  assign left_edge.found  = 1'b0;
  assign right_edge.entry = '0;
  assign right_edge.valid = 1'b0;
  assign right_edge.place = 1'b0;
  assign right_edge.found = 1'b0;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      dtq_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .new_entry  (new_entry),
        .del_id     (in_id),
        .left_link  ((g == 0) ? left_edge : links[(g == 0) ? 0 : g - 1]),
        .right_link ((g == DEPTH - 1) ? right_edge : links[(g == DEPTH - 1) ? g : g + 1]),
        .link       (links[g])
      );
    end
  endgenerate

  // Lowest free id
  always_comb begin
    free_id = '0;
    for (int i = NUM_IDS - 1; i >= 0; i--) begin
      if (!id_use_r[i]) begin
        free_id = ID_BITS'(i);
      end
    end
  end

  assign full       = links[DEPTH-1].valid || (&id_use_r);
  assign found      = links[DEPTH-1].found;
  assign head_fired = links[0].valid && (links[0].entry.expire < now_r);
  assign next_fired = links[1].valid && (links[1].entry.expire < now_r);

  // Sequencer: next state, chain command and result
  always_comb begin
    state_nxt      = state_r;
    id_use_nxt     = id_use_r;
    now_nxt        = now_r;
    cmd            = CMD_HOLD;
    load           = 1'b0;
    out_status_nxt = ST_NONE;
    out_id_nxt     = '0;
    out_tag_nxt    = '0;
    out_expire_nxt = '0;
    out_last_nxt   = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_op)
            OP_INSERT: begin
              load = 1'b1;
              if (full) begin
                out_status_nxt = ST_FULL;
              end else begin
                cmd                 = CMD_INSERT;
                out_status_nxt      = ST_INSERTED;
                out_id_nxt          = free_id;
                id_use_nxt[free_id] = 1'b1;
              end
            end
            OP_DELETE: begin
              load       = 1'b1;
              out_id_nxt = in_id;
              if (found) begin
                cmd               = CMD_DELETE;
                out_status_nxt    = ST_DELETED;
                id_use_nxt[in_id] = 1'b0;
              end else begin
                out_status_nxt = ST_NOTFOUND;
              end
            end
            OP_TICK: begin
              now_nxt   = in_now;
              state_nxt = S_TICK;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_TICK: begin
        if (slot_free) begin
          load = 1'b1;
          if (head_fired) begin
            cmd                           = CMD_POP;
            out_status_nxt                = ST_FIRED;
            out_id_nxt                    = links[0].entry.id;
            out_tag_nxt                   = links[0].entry.tag;
            out_expire_nxt                = links[0].entry.expire;
            out_last_nxt                  = !next_fired;
            id_use_nxt[links[0].entry.id] = 1'b0;
            if (!next_fired) begin
              state_nxt = S_IDLE;
            end
          end else begin
            out_status_nxt = ST_NONE;
            state_nxt      = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      id_use_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      id_use_r <= id_use_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    now_r <= now_nxt;
    if (load) begin
      out_status_r <= out_status_nxt;
      out_id_r     <= out_id_nxt;
      out_tag_r    <= out_tag_nxt;
      out_expire_r <= out_expire_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {4'b0, EXT_TIME_BITS'(out_expire_r), out_tag_r, out_id_r};

endmodule

// ===== test/deadline_timer_queue_test.sv =====
`timescale 1ns / 1ps

module deadline_timer_queue_test;
  import dtq_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam time_t NEVER = '1;  // latest deadline a cell can hold
  localparam int RANDOM_ITEMS = 80;
  localparam int MAX_WAIT = 14;
  localparam int IDLE_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 40;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    status_t status;
    id_t     id;
    tag_t    tag;
    time_t   expire;
    logic    last;
  } timer_result_t;

  typedef struct {
    logic [1:0] op;
    time_t      expire;
    tag_t       tag;
    id_t        del_id;
    time_t      now;
    bit         typed;        // single result given in the table itself
    status_t    want_status;
    id_t        want_id;
  } stim_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [1:0]   in_tuser = '0;
  logic [103:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [2:0]   out_tuser;
  logic [71:0]  out_tdata;
  logic         out_tlast;

  // Shadow of the deadline-ordered cells
  time_t              shadow_expire [DEPTH];
  tag_t               shadow_tag [DEPTH];
  id_t                shadow_id [DEPTH];
  int                 shadow_count = 0;
  logic [NUM_IDS-1:0] ids_busy = '0;

  timer_result_t awaited_results[$];
  stim_row_t     directed_rows[$];
  int            mismatches = 0;
  int            idle_cycles = 0;
  bit            send_burst = 1'b0;
  bit            recv_burst = 1'b0;

  deadline_timer_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #10 clk = ~clk;

  function automatic void await_result(status_t st, id_t id, tag_t tag, time_t exp,
                                       logic last);
    timer_result_t r;
    r.status = st;
    r.id     = id;
    r.tag    = tag;
    r.expire = exp;
    r.last   = last;
    awaited_results.push_back(r);
  endfunction

  // Close the gap left by the entry at pos
  function automatic void drop_entry(int pos);
    for (int k = pos; k + 1 < shadow_count; k++) begin
      shadow_expire[k] = shadow_expire[k+1];
      shadow_tag[k]    = shadow_tag[k+1];
      shadow_id[k]     = shadow_id[k+1];
    end
    shadow_count--;
  endfunction

  // Apply one transaction to the shadow queue and queue up what it answers
  function automatic void predict_timer_results(logic [1:0] op, time_t exp, tag_t tag,
                                                id_t del_id, time_t now);
    int  pos;
    int  free_id;
    int  hit;
    int  fired;
    id_t gone;
    pos = 0;
    free_id = -1;
    hit = -1;
    fired = 0;
    case (op)
      OP_INSERT: begin
        for (int k = NUM_IDS - 1; k >= 0; k--)
          if (!ids_busy[k]) free_id = k;
        if (shadow_count >= DEPTH || free_id < 0) begin
          await_result(ST_FULL, '0, '0, '0, 1'b1);
        end else begin
          // after every entry with an equal or earlier deadline
          while (pos < shadow_count && shadow_expire[pos] <= exp) pos++;
          for (int k = shadow_count; k > pos; k--) begin
            shadow_expire[k] = shadow_expire[k-1];
            shadow_tag[k]    = shadow_tag[k-1];
            shadow_id[k]     = shadow_id[k-1];
          end
          shadow_expire[pos] = exp;
          shadow_tag[pos]    = tag;
          shadow_id[pos]     = id_t'(free_id);
          shadow_count++;
          ids_busy[free_id] = 1'b1;
          await_result(ST_INSERTED, id_t'(free_id), '0, '0, 1'b1);
        end
      end
      OP_DELETE: begin
        for (int k = 0; k < shadow_count; k++)
          if (hit < 0 && shadow_id[k] == del_id) hit = k;
        if (hit < 0) begin
          await_result(ST_NOTFOUND, del_id, '0, '0, 1'b1);
        end else begin
          drop_entry(hit);
          ids_busy[del_id] = 1'b0;
          await_result(ST_DELETED, del_id, '0, '0, 1'b1);
        end
      end
      OP_TICK: begin
        // pop while the head deadline is strictly below the current time
        while (shadow_count > 0 && shadow_expire[0] < now) begin
          gone = shadow_id[0];
          await_result(ST_FIRED, gone, shadow_tag[0], shadow_expire[0], 1'b0);
          ids_busy[gone] = 1'b0;
          drop_entry(0);
          fired++;
        end
        if (fired == 0) await_result(ST_NONE, '0, '0, '0, 1'b1);
        else awaited_results[awaited_results.size()-1].last = 1'b1;
      end
      default: ;  // unused opcode changes nothing
    endcase
  endfunction

  function automatic void add_row(logic [1:0] op, time_t exp, tag_t tag, id_t del_id,
                                  time_t now, bit typed, status_t st, id_t want_id);
    stim_row_t row;
    row.op          = op;
    row.expire      = exp;
    row.tag         = tag;
    row.del_id      = del_id;
    row.now         = now;
    row.typed       = typed;
    row.want_status = st;
    row.want_id     = want_id;
    directed_rows.push_back(row);
  endfunction

  // Send one transaction after a random gap; valid stays high on back-to-back items
  task automatic issue_item(stim_row_t row);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
    if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tuser  <= row.op;
    in_tdata  <= {4'b0, row.now, row.del_id, row.tag, row.expire};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (in_tready !== 1'b1);
    predict_timer_results(row.op, row.expire, row.tag, row.del_id, row.now);
    if (row.typed) begin
      void'(awaited_results.pop_back());
      await_result(row.want_status, row.want_id, '0, '0, 1'b1);
    end
  endtask

  // Stimulus: directed table, then random traffic
  initial begin : stimulus
    stim_row_t row;
    int        sent;
    int        pick;
    bit        drained_once;
    time_t     wall_ms;

    // empty queue: nothing to fire, unknown id, ignored opcode
    add_row(OP_TICK, '0, '0, '0, NEVER, 1'b1, ST_NONE, '0);
    add_row(OP_DELETE, '0, '0, 4'd15, '0, 1'b1, ST_NOTFOUND, 4'd15);
    add_row(OP_UNUSED, NEVER, '1, 4'd15, NEVER, 1'b0, ST_NONE, '0);
    // fill every cell; ids come out in order, deadlines mix extremes and ties
    for (int k = 0; k < NUM_IDS; k++)
      add_row(OP_INSERT,
              (k == 0) ? NEVER : (k == 1) ? time_t'(0) : time_t'(1000 - 100 * (k % 4)),
              (k == 0) ? tag_t'('1) : tag_t'(32'h1111_1111 * (k - 1)),
              '0, '0, 1'b1, ST_INSERTED, id_t'(k));
    add_row(OP_INSERT, 32'd5, 32'hdead_beef, '0, '0, 1'b1, ST_FULL, '0);
    add_row(OP_DELETE, '0, '0, 4'd7, '0, 1'b1, ST_DELETED, 4'd7);
    // everything but the latest deadline fires, ties in insertion order
    add_row(OP_TICK, '0, '0, '0, NEVER, 1'b0, ST_NONE, '0);
    // latest deadline is not strictly below the largest time
    add_row(OP_TICK, '0, '0, '0, NEVER, 1'b1, ST_NONE, '0);
    add_row(OP_DELETE, '0, '0, 4'd0, '0, 1'b1, ST_DELETED, 4'd0);
    add_row(OP_INSERT, 32'd100, 32'ha5a5_5a5a, '0, '0, 1'b1, ST_INSERTED, 4'd0);
    // boundary: equal time does not fire, one later does
    add_row(OP_TICK, '0, '0, '0, 32'd100, 1'b1, ST_NONE, '0);
    add_row(OP_TICK, '0, '0, '0, 32'd101, 1'b0, ST_NONE, '0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) issue_item(directed_rows[i]);

    // random traffic around a slowly advancing wall clock
    wall_ms = $urandom_range(200, 1000);
    sent = 0;
    drained_once = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      // unused fields carry noise
      row.expire = $urandom;
      row.tag    = $urandom;
      row.del_id = id_t'($urandom);
      row.now    = $urandom;
      row.typed  = 1'b0;
      row.want_status = ST_NONE;
      row.want_id = '0;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        row.op = OP_UNUSED;
      end else if (pick < 52) begin
        row.op = OP_INSERT;
        pick = $urandom_range(0, 19);
        if (pick == 0) row.expire = '0;
        else if (pick == 1) row.expire = NEVER;
        else if (pick < 6 && shadow_count > 0)
          row.expire = shadow_expire[$urandom_range(0, shadow_count - 1)];
        else if (pick != 2) row.expire = wall_ms + $urandom_range(0, 400);
      end else if (pick < 72) begin
        row.op = OP_DELETE;
        if (shadow_count > 0 && $urandom_range(0, 3) != 0)
          row.del_id = shadow_id[$urandom_range(0, shadow_count - 1)];
      end else begin
        row.op = OP_TICK;
        wall_ms = wall_ms + $urandom_range(0, 150);
        pick = $urandom_range(0, 29);
        if (pick == 0) row.now = '0;
        else if (pick == 1) row.now = NEVER;
        else if (pick != 2) row.now = wall_ms;
      end
      issue_item(row);
      if (row.op != OP_UNUSED) sent++;
      // hold off until every pending result is out
      if (!drained_once && sent == RANDOM_ITEMS / 2) begin
        drained_once = 1'b1;
        in_tvalid <= 1'b0;
        do @(posedge clk); while (awaited_results.size() > 0);
      end
    end

    in_tvalid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // Result side: random stalls, compare each transaction with the oldest expectation
  initial begin : result_sink
    timer_result_t got;
    timer_result_t want;
    int            stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = recv_burst ? 0 : $urandom_range(0, MAX_WAIT);
      if ($urandom_range(0, 15) == 0) recv_burst = !recv_burst;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      got = {out_tuser, out_tdata[3:0], out_tdata[35:4], out_tdata[67:36], out_tlast};
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: unexpected result status %0d id %0d tag %h expire %h last %b",
                   $time, got.status, got.id, got.tag, got.expire, got.last);
      end else begin
        want = awaited_results.pop_front();
        if (got.status !== want.status || got.id !== want.id || got.tag !== want.tag ||
            got.expire !== want.expire || got.last !== want.last ||
            out_tdata[71:68] !== 4'h0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: exp %0d %0d %h %h %b | got %0d %0d %h %h %b pad %h",
                     $time, want.status, want.id, want.tag, want.expire, want.last,
                     got.status, got.id, got.tag, got.expire, got.last, out_tdata[71:68]);
        end
      end
    end
  end

  // Watchdog: too long without any transaction on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready === 1'b1) || (out_tvalid === 1'b1 && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule

// ===== deadline_timer_queue.f =====
rtl/dtq_pkg.sv
rtl/dtq_cell.sv
rtl/deadline_timer_queue.sv
test/deadline_timer_queue_test.sv
